[rtl/qsd_pkg.sv]
// Shared types and constants of the QAM soft/hard demapper.
package qsd_pkg;

   localparam int CSR_IDX_WIDTH  = 2;
   localparam int CSR_DATA_WIDTH = 16;
   localparam int VALUE_WIDTH    = 16;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_SOFT_MODE = 2'd0,
      CSR_BITS      = 2'd1,
      CSR_INV_VAR   = 2'd2
   } csr_index_type;

   typedef enum logic {
      KIND_LOAD   = 1'b0,
      KIND_SYMBOL = 1'b1
   } kind_type;

   typedef struct packed {
      logic soft_mode;
      logic [3:0] bits;
      logic [15:0] inv_var;
   } cfg_type;

endpackage

[rtl/qsd_stream_if.sv]
// Valid/ready channel with a generic payload.
interface qsd_stream_if #(
   parameter type payload_type = logic
);
   logic valid;
   logic ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[rtl/qsd_front.sv]
// Front end: accepts transactions, writes table points, queues symbols.
module qsd_front #(
   parameter int QUARTER_DEPTH = 64,
   parameter int SAMPLE_WIDTH = 16,
   localparam int QW = (QUARTER_DEPTH > 1) ? $clog2(QUARTER_DEPTH) : 1
) (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  logic in_kind,
   input  logic [5:0] in_index,
   input  logic signed [SAMPLE_WIDTH-1:0] in_re,
   input  logic signed [SAMPLE_WIDTH-1:0] in_im,
   input  logic in_end,
   input  logic back_idle,
   output logic wr_en,
   output logic [QW-1:0] wr_addr,
   output logic signed [SAMPLE_WIDTH-1:0] wr_re,
   output logic signed [SAMPLE_WIDTH-1:0] wr_im,
   output logic q_valid,
   input  logic q_pop,
   output logic signed [SAMPLE_WIDTH-1:0] q_re,
   output logic signed [SAMPLE_WIDTH-1:0] q_im,
   output logic q_end
);
   import qsd_pkg::*;

   logic [1:0] cnt_ff, cnt_in;
   logic rd_ff, rd_in, wrp_ff, wrp_in;
   logic signed [SAMPLE_WIDTH-1:0] re_ff [2];
   logic signed [SAMPLE_WIDTH-1:0] im_ff [2];
   logic end_ff [2];
   logic acc, push;

   // load items wait while symbols are queued or scanned so table writes keep order
   assign in_ready = (in_kind == KIND_LOAD) ? (cnt_ff == 2'd0 && !q_pop && back_idle)
                                            : (cnt_ff != 2'd2);
   assign acc = in_valid && in_ready;
   assign push = acc && (in_kind == KIND_SYMBOL);
   assign wr_en = acc && (in_kind == KIND_LOAD) && ({26'd0, in_index} < QUARTER_DEPTH);
   assign wr_addr = in_index[QW-1:0];
   assign wr_re = in_re;
   assign wr_im = in_im;

   assign q_valid = cnt_ff != 2'd0;
   assign q_re = re_ff[rd_ff];
   assign q_im = im_ff[rd_ff];
   assign q_end = end_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, q_pop};
      rd_in = rd_ff ^ q_pop;
      wrp_in = wrp_ff ^ push;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff <= 1'b0;
         wrp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
         wrp_ff <= wrp_in;
      end
      if (push) begin
         re_ff[wrp_ff] <= in_re;
         im_ff[wrp_ff] <= in_im;
         end_ff[wrp_ff] <= in_end;
      end
   end

   assert property (@(posedge clock) disable iff (reset) cnt_ff != 2'd3)
      else $error("queue count out of range");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> q_valid)
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset) !(wr_en && q_valid))
      else $error("table write with symbols queued");
   assert property (@(posedge clock) disable iff (reset) wr_en |-> back_idle)
      else $error("table write during scan");
endmodule

[rtl/qsd_back.sv]
// Back end: point scan, iterative square root, per-bit minimum and output.
module qsd_back #(
   parameter int MAX_BITS = 8,
   parameter int QUARTER_DEPTH = 64,
   parameter int SAMPLE_WIDTH = 16,
   localparam int QW = (QUARTER_DEPTH > 1) ? $clog2(QUARTER_DEPTH) : 1
) (
   input  logic clock,
   input  logic reset,
   input  qsd_pkg::cfg_type cfg,
   input  logic wr_en,
   input  logic [QW-1:0] wr_addr,
   input  logic signed [SAMPLE_WIDTH-1:0] wr_re,
   input  logic signed [SAMPLE_WIDTH-1:0] wr_im,
   input  logic q_valid,
   output logic q_pop,
   input  logic signed [SAMPLE_WIDTH-1:0] q_re,
   input  logic signed [SAMPLE_WIDTH-1:0] q_im,
   input  logic q_end,
   output logic idle,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [qsd_pkg::VALUE_WIDTH-1:0] out_value,
   output logic out_last,
   output logic out_blast
);
   import qsd_pkg::*;

   localparam int DW = SAMPLE_WIDTH + 2;
   localparam int SQW = 2 * DW;
   localparam int RW = DW + 1;
   localparam int LW = MAX_BITS;
   localparam int BW = $clog2(MAX_BITS + 1);
   localparam int SW = $clog2(RW + 1);
   localparam int PW = RW + 1 + 17;
   localparam int NW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_DIFF, S_SQR, S_ROOT, S_MIN, S_EMIT
   } state_type;

   logic signed [SAMPLE_WIDTH-1:0] mem_re [QUARTER_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] mem_im [QUARTER_DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] rd_re_ff, rd_im_ff;

   state_type state_ff;
   logic [LW-1:0] k_ff;
   logic [BW-1:0] b_ff, n_ff;
   logic [QW-1:0] j_ff;
   logic soft_ff, end_ff;
   logic [15:0] inv_ff;
   logic signed [SAMPLE_WIDTH-1:0] sr_ff, si_ff;
   logic signed [DW-1:0] dr_ff, di_ff;
   logic [SQW-1:0] rem_ff;
   logic [RW-1:0] root_ff;
   logic [SW-1:0] step_ff;
   logic [RW-1:0] d0_ff [MAX_BITS];
   logic [RW-1:0] d1_ff [MAX_BITS];
   logic [RW-1:0] best_d_ff;
   logic [LW-1:0] best_ff;
   logic best_ok_ff;
   logic signed [VALUE_WIDTH-1:0] val_ff;
   logic ov_ff, last_ff, blast_ff;
   logic signed [PW-1:0] prod_ff;
   logic prod_ok_ff;

   logic [3:0] eb;
   logic [LW-1:0] size_m1;
   logic [1:0] quad;
   logic [QW-1:0] j_max;
   logic [SQW:0] trial;
   logic signed [RW:0] diff;
   logic signed [PW-1:0] prod;
   logic signed [PW-9:0] qv;
   logic [BW-1:0] bitpos;

   always_comb begin
      eb = {cfg.bits[3:1], 1'b0};
      if (eb < 4'd2) eb = 4'd2;
      for (int t = 0; t < 4; t++)
         if (eb > 4'd2 && (int'(eb) > MAX_BITS || (1 << (int'(eb) - 2)) > QUARTER_DEPTH))
            eb = eb - 4'd2;
   end

   always_comb begin
      size_m1 = LW'((1 << b_ff) - 1);
      quad = 2'(k_ff >> (b_ff - BW'(2)));
      j_max = QW'(((1 << b_ff) >> 2) - 1);
      trial = {1'b0, rem_ff} - ({1'b0, SQW'(root_ff)} << (step_ff + SW'(1)))
              - ((SQW + 1)'(1) << (2 * step_ff));
      bitpos = b_ff - BW'(1) - n_ff;
      diff = $signed({1'b0, d0_ff[bitpos[NW-1:0]]})
             - $signed({1'b0, d1_ff[bitpos[NW-1:0]]});
      prod = PW'(diff) * $signed({1'b0, inv_ff});
      qv = prod_ff[PW-1:8];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_re[wr_addr] <= wr_re;
         mem_im[wr_addr] <= wr_im;
      end
      rd_re_ff <= mem_re[j_ff];
      rd_im_ff <= mem_im[j_ff];
   end

   assign idle = (state_ff == S_IDLE);
   assign q_pop = (state_ff == S_IDLE) && q_valid;
   assign out_valid = (state_ff == S_EMIT) && !ov_ff ? 1'b0 : ov_ff;
   assign out_value = val_ff;
   assign out_last = last_ff;
   assign out_blast = blast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff <= 1'b0;
         prod_ok_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  sr_ff <= q_re;
                  si_ff <= q_im;
                  end_ff <= q_end;
                  soft_ff <= cfg.soft_mode;
                  inv_ff <= cfg.inv_var;
                  b_ff <= BW'(eb);
                  k_ff <= '0;
                  j_ff <= '0;
                  best_ok_ff <= 1'b0;
                  for (int t = 0; t < MAX_BITS; t++) begin
                     d0_ff[t] <= '1;
                     d1_ff[t] <= '1;
                  end
                  state_ff <= S_READ;
               end
            end
            S_READ: state_ff <= S_DIFF;
            S_DIFF: begin
               dr_ff <= DW'(sr_ff) - ((quad[0]) ? -DW'(rd_re_ff) : DW'(rd_re_ff));
               di_ff <= DW'(si_ff) - ((quad[1]) ? -DW'(rd_im_ff) : DW'(rd_im_ff));
               state_ff <= S_SQR;
            end
            S_SQR: begin
               rem_ff <= SQW'(dr_ff * dr_ff) + SQW'(di_ff * di_ff);
               root_ff <= '0;
               step_ff <= SW'(RW - 1);
               state_ff <= S_ROOT;
            end
            S_ROOT: begin
               // restoring square root, one result bit a cycle
               if (!trial[SQW]) begin
                  rem_ff <= trial[SQW-1:0];
                  root_ff <= root_ff | (RW'(1) << step_ff);
               end
               if (step_ff == '0) state_ff <= S_MIN;
               else step_ff <= step_ff - SW'(1);
            end
            S_MIN: begin
               for (int t = 0; t < MAX_BITS; t++) begin
                  if (t < int'(b_ff)) begin
                     if (k_ff[t]) begin
                        if (root_ff < d1_ff[t]) d1_ff[t] <= root_ff;
                     end else begin
                        if (root_ff < d0_ff[t]) d0_ff[t] <= root_ff;
                     end
                  end
               end
               if (!best_ok_ff || root_ff < best_d_ff) begin
                  best_d_ff <= root_ff;
                  best_ff <= k_ff;
                  best_ok_ff <= 1'b1;
               end
               if (k_ff == size_m1) begin
                  n_ff <= '0;
                  prod_ok_ff <= 1'b0;
                  state_ff <= S_EMIT;
               end else begin
                  k_ff <= k_ff + LW'(1);
                  j_ff <= (j_ff == j_max) ? '0 : j_ff + QW'(1);
                  state_ff <= S_READ;
               end
            end
            S_EMIT: begin
               if (ov_ff) begin
                  if (out_ready) begin
                     ov_ff <= 1'b0;
                     prod_ok_ff <= 1'b0;
                     if (last_ff) state_ff <= S_IDLE;
                     else n_ff <= n_ff + BW'(1);
                  end
               end else if (!prod_ok_ff) begin
                  prod_ff <= prod;
                  prod_ok_ff <= 1'b1;
               end else begin
                  if (soft_ff) begin
                     if (qv > PW'(32767)) val_ff <= 16'sd32767;
                     else if (qv < -PW'(32768)) val_ff <= -16'sd32768;
                     else val_ff <= VALUE_WIDTH'(qv);
                  end else begin
                     val_ff <= VALUE_WIDTH'(best_ff[bitpos[$clog2(LW)-1:0]]);
                  end
                  last_ff <= (n_ff == b_ff - BW'(1));
                  blast_ff <= (n_ff == b_ff - BW'(1)) && end_ff;
                  ov_ff <= 1'b1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) ov_ff |-> state_ff == S_EMIT)
      else $error("result outside emit");
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_ready) |=> ov_ff && $stable(val_ff))
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset) q_pop |-> !ov_ff)
      else $error("pop during emit");
endmodule

[rtl/qam_soft_hard_demapper_unit.sv]
// Top level of the QAM soft/hard demapper.
//  channel | dir | handshake          | payload
//  req     | in  | req_valid/ready    | kind, point_index, sample_re/im, block_end
//  rsp     | out | rsp_valid/ready    | bit_value, last_bit, block_last
//  csr     | in  | csr_write_en       | csr_index, csr_data
// Each point passes through read, difference, square, bit-serial square root and
// minimum update; a symbol takes one pop, a scan over the 2^b points of the active
// size, then its output bits, which stall while rsp_ready is low. Loads wait until
// no symbol is queued or scanned. Reset is synchronous and clears control only;
// table entries stay undefined until written.
// A two-entry queue decouples intake from the scan.
module qam_soft_hard_demapper_unit #(
   parameter int MAX_BITS = 8,
   parameter int QUARTER_DEPTH = 64,
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_kind,
   input  logic [5:0] req_point_index,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_re,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample_im,
   input  logic req_block_end,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [qsd_pkg::VALUE_WIDTH-1:0] rsp_bit_value,
   output logic rsp_last_bit,
   output logic rsp_block_last,
   input  logic csr_write_en,
   input  logic [qsd_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [qsd_pkg::CSR_DATA_WIDTH-1:0] csr_data
);
   import qsd_pkg::*;

   localparam int QW = (QUARTER_DEPTH > 1) ? $clog2(QUARTER_DEPTH) : 1;

   cfg_type cfg_ff;
   logic wr_en, q_valid, q_pop, q_end, back_idle;
   logic [QW-1:0] wr_addr;
   logic signed [SAMPLE_WIDTH-1:0] wr_re, wr_im, q_re, q_im;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.soft_mode <= 1'b1;
         cfg_ff.bits <= 4'd4;
         cfg_ff.inv_var <= 16'd256;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SOFT_MODE: cfg_ff.soft_mode <= csr_data[0];
            CSR_BITS:      cfg_ff.bits <= csr_data[3:0];
            CSR_INV_VAR:   cfg_ff.inv_var <= csr_data;
            default: ;
         endcase
      end
   end

   qsd_front #(.QUARTER_DEPTH(QUARTER_DEPTH), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_kind(req_kind),
      .in_index(req_point_index), .in_re(req_sample_re), .in_im(req_sample_im),
      .in_end(req_block_end), .back_idle,
      .wr_en, .wr_addr, .wr_re, .wr_im,
      .q_valid, .q_pop, .q_re, .q_im, .q_end
   );

   qsd_back #(.MAX_BITS(MAX_BITS), .QUARTER_DEPTH(QUARTER_DEPTH),
              .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_back (
      .clock, .reset, .cfg(cfg_ff),
      .wr_en, .wr_addr, .wr_re, .wr_im,
      .q_valid, .q_pop, .q_re, .q_im, .q_end,
      .idle(back_idle),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_value(rsp_bit_value),
      .out_last(rsp_last_bit), .out_blast(rsp_block_last)
   );
endmodule

[dv/qam_soft_hard_demapper_unit_tb.sv]
// Self-checking testbench of the QAM soft/hard demapper: random and directed traffic, scoreboard.
module qam_soft_hard_demapper_unit_tb;
   import qsd_pkg::*;

   typedef struct packed {
      kind_type kind;
      logic [5:0] point_index;
      logic signed [15:0] sample_re;
      logic signed [15:0] sample_im;
      logic block_end;
   } symbol_req_type;

   typedef struct packed {
      logic signed [15:0] bit_value;
      logic last_bit;
      logic block_last;
   } bit_rsp_type;

   class demap_scoreboard;
      int point_re[64];
      int point_im[64];
      bit soft_mode = 1'b1;
      logic [3:0] bits = 4'd4;
      logic [15:0] inv_var = 16'd256;
      bit_rsp_type expected_bits[$];
      int mismatches;
      int symbols;
      int loads;
      int bits_checked;

      function void write_reg(csr_index_type idx, logic [15:0] data);
         case (idx)
            CSR_SOFT_MODE: soft_mode = data[0];
            CSR_BITS: bits = data[3:0];
            CSR_INV_VAR: inv_var = data;
            default: ;
         endcase
      endfunction

      function int active_bits();
         int b;
         b = bits & 4'he;
         if (b < 2) b = 2;
         while (b > 2 && (b > 8 || ((1 << b) >> 2) > 64)) b -= 2;
         return b;
      endfunction

      function longint isqrt(longint unsigned v);
         longint unsigned res, step;
         res = 0;
         step = 64'd1 << 62;
         while (step > v) step = step >> 2;
         while (step != 0) begin
            if (v >= res + step) begin
               v = v - (res + step);
               res = (res >> 1) + step;
            end else begin
               res = res >> 1;
            end
            step = step >> 2;
         end
         return longint'(res);
      endfunction

      function void note_input(symbol_req_type t);
         longint dist_tab[256];
         int b, size, quarter, q, j, best, bitpos;
         longint pr, pi, dr, di, d0, d1, p, v;
         bit_rsp_type r;
         if (t.kind == KIND_LOAD) begin
            point_re[t.point_index] = t.sample_re;
            point_im[t.point_index] = t.sample_im;
            loads++;
            return;
         end
         symbols++;
         b = active_bits();
         size = 1 << b;
         quarter = size >> 2;
         for (int k = 0; k < size; k++) begin
            q = k / quarter;
            j = k % quarter;
            pr = point_re[j];
            pi = point_im[j];
            if (q == 1 || q == 3) pr = -pr;
            if (q == 2 || q == 3) pi = -pi;
            dr = longint'(t.sample_re) - pr;
            di = longint'(t.sample_im) - pi;
            dist_tab[k] = isqrt(longint'(dr * dr + di * di));
         end
         best = 0;
         for (int k = 1; k < size; k++)
            if (dist_tab[k] < dist_tab[best]) best = k;
         for (int n = 0; n < b; n++) begin
            bitpos = b - 1 - n;
            if (soft_mode) begin
               d0 = 64'h7fff_ffff_ffff;
               d1 = 64'h7fff_ffff_ffff;
               for (int k = 0; k < size; k++) begin
                  if ((k >> bitpos) & 1) begin
                     if (dist_tab[k] < d1) d1 = dist_tab[k];
                  end else begin
                     if (dist_tab[k] < d0) d0 = dist_tab[k];
                  end
               end
               p = (d0 - d1) * longint'(inv_var);
               v = p >>> 8;
               if (v > 32767) v = 32767;
               if (v < -32768) v = -32768;
               r.bit_value = v[15:0];
            end else begin
               r.bit_value = 16'((best >> bitpos) & 1);
            end
            r.last_bit = (n == b - 1);
            r.block_last = (n == b - 1) ? t.block_end : 1'b0;
            expected_bits.push_back(r);
         end
      endfunction

      function void check_result(bit_rsp_type got);
         bit_rsp_type exp_bit;
         bits_checked++;
         if (expected_bits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transaction: value %0d last %0b block %0b",
                        got.bit_value, got.last_bit, got.block_last);
            return;
         end
         exp_bit = expected_bits.pop_front();
         if (got !== exp_bit) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: value exp %0d got %0d, last exp %0b got %0b, block exp %0b got %0b",
                        exp_bit.bit_value, got.bit_value, exp_bit.last_bit, got.last_bit,
                        exp_bit.block_last, got.block_last);
         end
      endfunction
   endclass

   localparam int IDLE_LIMIT = 40000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0] csr_data = '0;

   qsd_stream_if #(.payload_type(symbol_req_type)) req_ch ();
   qsd_stream_if #(.payload_type(bit_rsp_type)) rsp_ch ();

   demap_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int holdoff_request = 0;
   int holdoff_left = 0;
   int idle_cycles = 0;

   qam_soft_hard_demapper_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_kind(req_ch.payload.kind),
      .req_point_index(req_ch.payload.point_index),
      .req_sample_re(req_ch.payload.sample_re),
      .req_sample_im(req_ch.payload.sample_im),
      .req_block_end(req_ch.payload.block_end),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_bit_value(rsp_ch.payload.bit_value),
      .rsp_last_bit(rsp_ch.payload.last_bit),
      .rsp_block_last(rsp_ch.payload.block_last),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (holdoff_request > 0) begin
         holdoff_left = holdoff_request;
         holdoff_request = 0;
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) sb.note_input(req_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.payload);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send(symbol_req_type t);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= t;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic send_load(int idx, int re, int im);
      symbol_req_type t;
      t = '0;
      t.kind = KIND_LOAD;
      t.point_index = idx[5:0];
      t.sample_re = re[15:0];
      t.sample_im = im[15:0];
      t.block_end = $urandom_range(1);
      send(t);
   endtask

   task automatic send_symbol(int re, int im, bit last);
      symbol_req_type t;
      t.kind = KIND_SYMBOL;
      t.point_index = 6'($urandom_range(63));
      t.sample_re = re[15:0];
      t.sample_im = im[15:0];
      t.block_end = last;
      send(t);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.expected_bits.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data[15:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_reg(idx, data[15:0]);
      @(posedge clock);
   endtask

   task automatic random_traffic(int count);
      int j, r;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(99);
         j = $urandom_range(63);
         if (r < 12) begin
            send_load(j, $urandom_range(65535), $urandom_range(65535));
         end else if (r < 40) begin
            send_symbol($urandom_range(65535), $urandom_range(65535), $urandom_range(1));
         end else begin
            send_symbol(sb.point_re[j] * ($urandom_range(1) ? 1 : -1) +
                        $urandom_range(2000) - 1000,
                        sb.point_im[j] * ($urandom_range(1) ? 1 : -1) +
                        $urandom_range(2000) - 1000, $urandom_range(1));
         end
      end
   endtask

   task automatic random_config();
      int b;
      b = $urandom_range(99);
      write_reg(CSR_SOFT_MODE, $urandom_range(1));
      write_reg(CSR_BITS, b < 45 ? 2 : b < 85 ? 4 : b < 92 ? 6 : $urandom_range(15));
      write_reg(CSR_INV_VAR, $urandom_range(3) == 0 ? 65535 : $urandom_range(2047));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_load(0, -32768, -32768);
      send_load(1, 32767, 32767);
      send_load(2, 0, 0);
      for (int i = 3; i < 64; i++)
         send_load(i, $urandom_range(16383), $urandom_range(16383));

      send_symbol(-32768, -32768, 1'b0);
      send_symbol(32767, 32767, 1'b1);
      send_symbol(0, 0, 1'b1);
      send_symbol(-32768, 32767, 1'b0);
      drain();
      write_reg(CSR_INV_VAR, 65535);
      write_reg(CSR_BITS, 15);
      send_symbol(1000, -1000, 1'b1);
      drain();
      write_reg(CSR_INV_VAR, 0);
      write_reg(CSR_BITS, 0);
      send_symbol(32767, -32768, 1'b1);
      drain();
      write_reg(CSR_SOFT_MODE, 0);
      write_reg(CSR_BITS, 1);
      send_symbol(-5, 5, 1'b0);
      drain();
      write_reg(CSR_BITS, 7);
      send_symbol(-32768, 0, 1'b1);
      send_symbol(32767, 0, 1'b0);
      drain();
      write_reg(CSR_BITS, 8);
      send_symbol(0, 32767, 1'b1);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1) ? 74 : (phase == 3) ? 10 : 0;
         recv_stall_pct = (phase == 2) ? 74 : (phase == 3) ? 10 : 0;
         random_config();
         if (phase == 0) begin
            write_reg(CSR_BITS, 2);
            holdoff_request = 1500;
         end
         random_traffic(7);
         drain();
         random_config();
         random_traffic(7);
         drain();
      end

      repeat (50) @(posedge clock);
      $display("covered %0d symbols and %0d point loads, %0d result bits checked",
               sb.symbols, sb.loads, sb.bits_checked);
      $display("soft and hard modes, all constellation sizes, idle and stall phases");
      if (sb.mismatches == 0 && sb.expected_bits.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("%0d mismatches, %0d results missing", sb.mismatches,
                  sb.expected_bits.size());
         $display("RESULT: ERROR");
      end
      $finish;
   end
endmodule
